[src/hash_set_insert_lookup_assert.svh]
// Assertion macros for the hash set block.
`ifndef HASH_SET_INSERT_LOOKUP_ASSERT_SVH
`define HASH_SET_INSERT_LOOKUP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSIL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSIL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/hsil_pkg.sv]
package hsil_pkg;

    localparam int unsigned CAPACITY_DEFAULT = 1024;

    localparam logic [63:0] FNV_OFFSET    = 64'hCBF2_9CE4_8422_2325;
    // The FNV prime is 2^40 + 0x1B3, so a multiply is a shift plus a narrow product.
    localparam int unsigned FNV_SHIFT     = 40;
    localparam logic [63:0] FNV_PRIME_LOW = 64'h0000_0000_0000_01B3;

    localparam logic [3:0] KEY_BYTES_RESET = 4'd8;
    localparam logic [3:0] KEY_BYTES_MAX   = 4'd8;

    localparam int unsigned ENTRY_COUNT_W = 10;

    typedef enum logic [2:0] {
        ST_PRESENT  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_FOUND    = 3'd3,
        ST_ABSENT   = 3'd4
    } t_status;

    typedef enum logic {
        ACT_ADD   = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

endpackage

[src/hash_set_insert_lookup.sv]
// Hash set with open addressing and linear probing over one synchronous table
// memory of CAPACITY slots, each holding a used mark and a 64-bit key. After
// reset the block clears every slot in turn and accepts no item until that
// pass ends; the key_bytes register can be written at any time. An item is
// hashed over its active key bytes (one to eight), reduced to a home slot by
// long division when CAPACITY is not a power of two, and then probed slot by
// slot from the home slot (at least one slot is probed).
// The FNV-1a hash runs one key byte per cycle, the home slot is reduced eight
// hash bits per cycle when needed, and the probe walk examines one slot per
// cycle through the single table read port. One item is processed at a time;
// a finished result waits in an output register while the next item starts,
// and that next item holds its last probe until the waiting result is taken.
`include "hash_set_insert_lookup_assert.svh"

module hash_set_insert_lookup #(
    parameter int unsigned CAPACITY = hsil_pkg::CAPACITY_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [3:0]                           i_cfg_key_bytes,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_action,
    input  logic [63:0]                          i_key,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [2:0]                           o_status,
    output logic [hsil_pkg::ENTRY_COUNT_W-1:0]   o_entry_count
);

    localparam int unsigned AW      = $clog2(CAPACITY);
    localparam bit          IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
    localparam int unsigned LIMIT   = (3 * CAPACITY + 3) / 4;
    localparam int unsigned CW_RAW  = $clog2(LIMIT + 1);
    localparam int unsigned CW      = (CW_RAW > hsil_pkg::ENTRY_COUNT_W) ?
                                      CW_RAW : hsil_pkg::ENTRY_COUNT_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_MOD   = 6'b001000,
        S_HOME  = 6'b010000,
        S_CHECK = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [3:0]      r_key_bytes;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_clr, n_clr;
    logic            r_action;
    logic [63:0]     r_key, r_mask;
    logic [3:0]      r_nb;
    logic [2:0]      r_byte, n_byte;
    logic [63:0]     r_hash, n_hash;
    logic [2:0]      r_mod_cnt, n_mod_cnt;
    logic [AW-1:0]   r_rem, n_rem;
    logic [AW-1:0]   r_pos, n_pos;
    logic [AW-1:0]   r_steps, n_steps;
    logic            r_out_valid, n_out_valid;
    hsil_pkg::t_status r_status, n_status;

    logic [64:0]     r_mem [CAPACITY];
    logic [64:0]     r_rdata;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [64:0]     mem_wd;

    logic [3:0]      nb_in;
    logic [63:0]     mask_in;
    logic [63:0]     hx;
    logic [AW-1:0]   pos_next;
    logic            slot_used, slot_hit, last_probe, resolved, out_free, is_full;
    logic            do_insert;
    logic [AW:0]     rem_acc;

    // Active byte count: zero acts as one, anything above eight acts as eight.
    always_comb begin
        if (r_key_bytes == 4'd0) begin
            nb_in = 4'd1;
        end else if (r_key_bytes > hsil_pkg::KEY_BYTES_MAX) begin
            nb_in = hsil_pkg::KEY_BYTES_MAX;
        end else begin
            nb_in = r_key_bytes;
        end
        for (int i = 0; i < 8; i++) begin
            mask_in[i*8 +: 8] = (4'(i) < nb_in) ? 8'hFF : 8'h00;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_count = r_count[hsil_pkg::ENTRY_COUNT_W-1:0];

    assign hx         = r_hash ^ {56'd0, r_key[{r_byte, 3'b000} +: 8]};
    assign pos_next   = (r_pos == LAST_SLOT) ? '0 : r_pos + 1'b1;
    assign slot_used  = r_rdata[64];
    assign slot_hit   = slot_used && ((r_rdata[63:0] & r_mask) == r_key);
    assign last_probe = (r_steps == LAST_SLOT);
    assign resolved   = !slot_used || slot_hit || last_probe;
    assign out_free   = !r_out_valid || i_out_ready;
    assign is_full    = (r_count >= CW'(LIMIT));
    assign do_insert  = (r_state == S_CHECK) && resolved && out_free &&
                        (r_action == hsil_pkg::ACT_ADD) && !slot_used && !is_full;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_clr       = r_clr;
        n_byte      = r_byte;
        n_hash      = r_hash;
        n_mod_cnt   = r_mod_cnt;
        n_rem       = r_rem;
        n_pos       = r_pos;
        n_steps     = r_steps;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        rd_addr     = r_pos;
        mem_we      = 1'b0;
        mem_wa      = r_pos;
        mem_wd      = {1'b1, r_key};
        rem_acc     = '0;

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
                n_clr  = r_clr + 1'b1;
                if (r_clr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte  = '0;
                    n_hash  = hsil_pkg::FNV_OFFSET;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                n_hash = (hx << hsil_pkg::FNV_SHIFT) + hx * hsil_pkg::FNV_PRIME_LOW;
                n_byte = r_byte + 1'b1;
                if ({1'b0, r_byte} == r_nb - 4'd1) begin
                    n_mod_cnt = '0;
                    n_rem     = '0;
                    if (IS_POW2) begin
                        n_state = S_HOME;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                // Long division of the hash by CAPACITY, most significant byte first.
                rem_acc = {1'b0, r_rem};
                for (int b = 7; b >= 0; b--) begin
                    rem_acc = {rem_acc[AW-1:0], r_hash[{~r_mod_cnt, 3'b000} + b]};
                    if (rem_acc >= (AW+1)'(CAPACITY)) begin
                        rem_acc = rem_acc - (AW+1)'(CAPACITY);
                    end
                end
                n_rem     = rem_acc[AW-1:0];
                n_mod_cnt = r_mod_cnt + 1'b1;
                if (r_mod_cnt == 3'd7) begin
                    n_state = S_HOME;
                end
            end
            S_HOME: begin
                rd_addr = IS_POW2 ? r_hash[AW-1:0] : r_rem;
                n_pos   = rd_addr;
                n_steps = '0;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!resolved) begin
                    rd_addr = pos_next;
                    n_pos   = pos_next;
                    n_steps = r_steps + 1'b1;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_action == hsil_pkg::ACT_QUERY) begin
                        if (slot_hit) begin
                            n_status = hsil_pkg::ST_FOUND;
                        end else begin
                            n_status = hsil_pkg::ST_ABSENT;
                        end
                    end else if (slot_hit) begin
                        n_status = hsil_pkg::ST_PRESENT;
                    end else if (do_insert) begin
                        mem_we   = 1'b1;
                        n_count  = r_count + 1'b1;
                        n_status = hsil_pkg::ST_INSERTED;
                    end else begin
                        n_status = hsil_pkg::ST_FULL;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_key_bytes <= hsil_pkg::KEY_BYTES_RESET;
            r_count     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_byte      <= '0;
            r_mod_cnt   <= '0;
            r_steps     <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_byte      <= n_byte;
            r_mod_cnt   <= n_mod_cnt;
            r_steps     <= n_steps;
            if (i_cfg_valid) begin
                r_key_bytes <= i_cfg_key_bytes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_action <= i_action;
            r_key    <= i_key & mask_in;
            r_mask   <= mask_in;
            r_nb     <= nb_in;
        end
        r_hash   <= n_hash;
        r_rem    <= n_rem;
        r_pos    <= n_pos;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[rd_addr];
    end

    `HSIL_ASSERT_NOW(a_count_bounded, i_clk, i_rst_n, 1'b1, r_count <= CW'(LIMIT),
        "stored count exceeds the load limit")
    `HSIL_ASSERT_NOW(a_insert_below_limit, i_clk, i_rst_n, mem_we && r_state == S_CHECK,
        !is_full && !slot_used, "insert into a used slot or a full table")
    `HSIL_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n, r_state == S_CLEAR,
        !o_in_ready, "item accepted during the clearing pass")
    `HSIL_ASSERT_NOW(a_result_slot_free, i_clk, i_rst_n,
        r_state == S_CHECK && resolved && n_state == S_IDLE, out_free,
        "result loaded over an untaken result")
    `HSIL_ASSERT_NEXT(a_insert_counts, i_clk, i_rst_n, do_insert,
        r_count == $past(r_count) + 1'b1, "insert did not advance the count")

endmodule

[tb/sv/tb_top.sv]
module tb_top;

    localparam int unsigned TABLE_SLOTS  = hsil_pkg::CAPACITY_DEFAULT;
    localparam logic [63:0] FNV_PRIME    = 64'h0000_0100_0000_01B3;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned PHASE_ITEMS  = 62;

    typedef struct packed {
        hsil_pkg::t_status                  status;
        logic [hsil_pkg::ENTRY_COUNT_W-1:0] entry_count;
    } t_response;

    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [3:0]                         i_cfg_key_bytes = 4'd0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic                               i_action = 1'b0;
    logic [63:0]                        i_key = 64'd0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b1;
    logic [2:0]                         o_status;
    logic [hsil_pkg::ENTRY_COUNT_W-1:0] o_entry_count;

    // Shadow copy of the set, its occupancy and the key width register.
    logic        slot_taken [TABLE_SLOTS];
    logic [63:0] slot_value [TABLE_SLOTS];
    int unsigned key_count;
    logic [3:0]  key_bytes_shadow;

    t_response   pending_responses[$];
    t_response   head_resp;
    logic [63:0] seen_keys[$];
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned fail_count;

    hash_set_insert_lookup u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_key_bytes (i_cfg_key_bytes),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_key           (i_key),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int unsigned active_byte_count();
        if (key_bytes_shadow == 4'd0) begin
            return 1;
        end
        if (key_bytes_shadow > hsil_pkg::KEY_BYTES_MAX) begin
            return 8;
        end
        return int'(key_bytes_shadow);
    endfunction

    function automatic logic [63:0] fnv1a_hash(input logic [63:0] key, input int unsigned nbytes);
        logic [63:0] h;
        h = hsil_pkg::FNV_OFFSET;
        for (int unsigned i = 0; i < nbytes; i++) begin
            h = (h ^ {56'd0, key[i*8 +: 8]}) * FNV_PRIME;
        end
        return h;
    endfunction

    // Walks the probe chain from the home slot and applies an add to the shadow table.
    function automatic hsil_pkg::t_status predict_set_response(input hsil_pkg::t_action act,
                                                              input logic [63:0] raw_key);
        int unsigned nbytes;
        logic [63:0] mask;
        logic [63:0] key;
        int unsigned pos;
        bit          hit;
        bit          free_ok;
        nbytes = active_byte_count();
        mask = (nbytes >= 8) ? '1 : ((64'd1 << (nbytes * 8)) - 64'd1);
        key = raw_key & mask;
        pos = int'(fnv1a_hash(key, nbytes) % 64'(TABLE_SLOTS));
        hit = 1'b0;
        free_ok = 1'b0;
        for (int unsigned steps = 0; steps < TABLE_SLOTS && !hit && !free_ok; steps++) begin
            if (!slot_taken[pos]) begin
                free_ok = 1'b1;
            end else if ((slot_value[pos] & mask) == key) begin
                hit = 1'b1;
            end else begin
                pos = (pos + 1 == TABLE_SLOTS) ? 0 : pos + 1;
            end
        end
        if (act == hsil_pkg::ACT_QUERY) begin
            if (hit) begin
                return hsil_pkg::ST_FOUND;
            end
            return hsil_pkg::ST_ABSENT;
        end
        if (hit) begin
            return hsil_pkg::ST_PRESENT;
        end
        if (key_count * 4 >= TABLE_SLOTS * 3 || !free_ok) begin
            return hsil_pkg::ST_FULL;
        end
        slot_taken[pos] = 1'b1;
        slot_value[pos] = key;
        key_count++;
        return hsil_pkg::ST_INSERTED;
    endfunction

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SEND: begin
                send_idle_pct = 47;
                recv_stall_pct = 0;
            end
            IDLE_RECV: begin
                send_idle_pct = 0;
                recv_stall_pct = 47;
            end
            default: begin
                send_idle_pct = 34;
                recv_stall_pct = 34;
            end
        endcase
    endtask

    task automatic send_request(input hsil_pkg::t_action act, input logic [63:0] key);
        t_response resp;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_key <= key;
        do @(posedge i_clk); while (!o_in_ready);
        resp.status = predict_set_response(act, key);
        resp.entry_count = key_count[hsil_pkg::ENTRY_COUNT_W-1:0];
        pending_responses.push_back(resp);
        seen_keys.push_back(key);
    endtask

    // The sender stays quiet until every outstanding request has been answered.
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_responses.size() != 0);
    endtask

    task automatic set_key_bytes(input logic [3:0] value);
        wait_for_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_key_bytes <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        key_bytes_shadow = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Mixes reuse of earlier keys, narrow keys and fresh wide keys.
    function automatic logic [63:0] pick_key();
        int unsigned roll;
        logic [63:0] key;
        roll = $urandom_range(99);
        if (roll < 40 && seen_keys.size() != 0) begin
            key = seen_keys[$urandom_range(seen_keys.size() - 1)];
            if ($urandom_range(3) == 0) begin
                key[63:32] = $urandom;
            end
        end else if (roll < 52) begin
            key = 64'($urandom_range(255));
        end else begin
            key = {$urandom, $urandom};
        end
        return key;
    endfunction

    function automatic hsil_pkg::t_action pick_action();
        if ($urandom_range(1) == 0) begin
            return hsil_pkg::ACT_ADD;
        end
        return hsil_pkg::ACT_QUERY;
    endfunction

    task automatic test_directed();
        set_idling(IDLE_NONE);
        send_request(hsil_pkg::ACT_QUERY, 64'd0);
        send_request(hsil_pkg::ACT_ADD, 64'd0);
        send_request(hsil_pkg::ACT_ADD, 64'd0);
        send_request(hsil_pkg::ACT_QUERY, 64'd0);
        send_request(hsil_pkg::ACT_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(hsil_pkg::ACT_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(hsil_pkg::ACT_QUERY, 64'h8000_0000_0000_0000);
        send_request(hsil_pkg::ACT_ADD, 64'h5555_5555_5555_5555);
        send_request(hsil_pkg::ACT_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(hsil_pkg::ACT_QUERY, 64'h0000_0000_0000_0001);
        // Narrowing the key makes the stored zero key match anything with a zero low byte.
        set_key_bytes(4'd1);
        send_request(hsil_pkg::ACT_ADD, 64'hFFFF_FFFF_FFFF_FF00);
        send_request(hsil_pkg::ACT_QUERY, 64'h1234_5678_9ABC_DEFF);
        send_request(hsil_pkg::ACT_ADD, 64'hDEAD_BEEF_0000_0042);
        send_request(hsil_pkg::ACT_QUERY, 64'h0000_0000_0000_0042);
        // A zero width acts as one byte, and anything above eight acts as eight.
        set_key_bytes(4'd0);
        send_request(hsil_pkg::ACT_QUERY, 64'h0000_0000_0000_FF42);
        send_request(hsil_pkg::ACT_ADD, 64'h0000_0000_0000_0142);
        set_key_bytes(4'd15);
        send_request(hsil_pkg::ACT_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(hsil_pkg::ACT_ADD, 64'h0000_0000_0000_0042);
        send_request(hsil_pkg::ACT_QUERY, 64'h0000_0000_0000_0042);
        set_key_bytes(4'd4);
        send_request(hsil_pkg::ACT_QUERY, 64'hFFFF_FFFF_5555_5555);
        send_request(hsil_pkg::ACT_ADD, 64'h0000_0000_AAAA_AAAA);
        send_request(hsil_pkg::ACT_QUERY, 64'h1111_1111_AAAA_AAAA);
    endtask

    task automatic test_random_traffic();
        logic [3:0] widths[8];
        widths = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2, 4'd9};
        foreach (widths[w]) begin
            set_key_bytes(widths[w]);
            for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
                set_idling(t_idle_mode'(((w * PHASE_ITEMS + n) / 31) % 4));
                if (w == 2 && n == PHASE_ITEMS / 2) begin
                    wait_for_idle();
                end
                send_request(pick_action(), pick_key());
            end
        end
    endtask

    // Fills the table with wide keys up to its load limit and then presses against it.
    task automatic test_fill_until_full();
        int unsigned n;
        set_key_bytes(4'd8);
        n = 0;
        while (key_count * 4 < TABLE_SLOTS * 3) begin
            set_idling(t_idle_mode'((n / 100) % 4));
            if ($urandom_range(7) == 0) begin
                send_request(hsil_pkg::ACT_QUERY, pick_key());
            end else begin
                send_request(hsil_pkg::ACT_ADD, {$urandom, $urandom});
            end
            n++;
        end
        for (int unsigned i = 0; i < 40; i++) begin
            set_idling(t_idle_mode'((i / 10) % 4));
            send_request(pick_action(), pick_key());
        end
    endtask

    task automatic test_full_narrow_keys();
        set_key_bytes(4'd1);
        for (int unsigned i = 0; i < 24; i++) begin
            set_idling(t_idle_mode'(i % 4));
            send_request(pick_action(), {$urandom, $urandom});
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_responses.size() == 0) begin
                $error("result with no request outstanding: status %0d entry_count %0d",
                       o_status, o_entry_count);
                fail_count++;
            end else begin
                head_resp = pending_responses.pop_front();
                if (o_status !== head_resp.status) begin
                    $error("status: expected %0d, actual %0d", head_resp.status, o_status);
                    fail_count++;
                end
                if (o_entry_count !== head_resp.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           head_resp.entry_count, o_entry_count);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        for (int unsigned s = 0; s < TABLE_SLOTS; s++) begin
            slot_taken[s] = 1'b0;
            slot_value[s] = 64'd0;
        end
        key_count = 0;
        key_bytes_shadow = hsil_pkg::KEY_BYTES_RESET;
        fail_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_traffic();
        test_fill_until_full();
        test_full_narrow_keys();
        wait_for_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
